@@ src/vpso_pkg.sv @@
package vpso_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int DIGIT_W     = 24;
   localparam int DIG_IDX_W   = 2;
   localparam int TERM_W      = 4;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_MODEL_A21            = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MODEL_A22            = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT_GAIN           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OBSERVER_GAIN_FIRST  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OBSERVER_GAIN_SECOND = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_POLE          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_FEED          = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP            = 3'd7;

   localparam longint RST_MODEL_A21            = -585692611;
   localparam longint RST_MODEL_A22            = -232699986;
   localparam longint RST_INPUT_GAIN           = 12666798;
   localparam longint RST_OBSERVER_GAIN_FIRST  = 436207616;
   localparam longint RST_OBSERVER_GAIN_SECOND = 1056964608;
   localparam longint RST_FILTER_POLE          = 16257122;
   localparam longint RST_FILTER_FEED          = 260047;
   localparam longint RST_TIME_STEP            = 167772;

   // Product terms in the order the shared multiplier works through them.
   localparam logic [TERM_W-1:0] TERM_POLE     = 4'd0;
   localparam logic [TERM_W-1:0] TERM_FEED_NEW = 4'd1;
   localparam logic [TERM_W-1:0] TERM_FEED_OLD = 4'd2;
   localparam logic [TERM_W-1:0] TERM_K0       = 4'd3;
   localparam logic [TERM_W-1:0] TERM_A21      = 4'd4;
   localparam logic [TERM_W-1:0] TERM_A22      = 4'd5;
   localparam logic [TERM_W-1:0] TERM_GAIN     = 4'd6;
   localparam logic [TERM_W-1:0] TERM_K1       = 4'd7;
   localparam logic [TERM_W-1:0] TERM_STEP0    = 4'd8;
   localparam logic [TERM_W-1:0] TERM_STEP1    = 4'd9;

   typedef struct packed {
      logic                 acc_load;
      logic                 issue;
      logic [DIG_IDX_W-1:0] digit;
      logic [TERM_W-1:0]    term;
      logic                 round_wr;
      logic                 diff_wr;
      logic                 finish;
      logic                 idle;
   } seq_ctl_type;

   function automatic logic term_first(input logic [TERM_W-1:0] term);
      logic first;
      unique case (term) inside
         TERM_POLE, TERM_K0, TERM_A21, TERM_STEP0, TERM_STEP1: first = 1'b1;
         default: first = 1'b0;
      endcase
      return first;
   endfunction

   function automatic logic term_last(input logic [TERM_W-1:0] term);
      logic last;
      unique case (term) inside
         TERM_FEED_OLD, TERM_K0, TERM_K1, TERM_STEP0, TERM_STEP1: last = 1'b1;
         default: last = 1'b0;
      endcase
      return last;
   endfunction

endpackage

@@ src/vpso_mac.sv @@
module vpso_mac #(
   parameter int DATA_WIDTH = 40,
   parameter int COEF_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vpso_pkg::seq_ctl_type       ctl,
   input  logic [COEF_WIDTH-1:0]       coef_op,
   input  logic [DATA_WIDTH:0]         data_op,
   input  logic [DATA_WIDTH-1:0]       init_op,
   output logic [DATA_WIDTH-1:0]       result
);
   import vpso_pkg::*;

   localparam int DW1     = DATA_WIDTH + 1;
   localparam int NDIG    = (DW1 + DIGIT_W - 1) / DIGIT_W;
   localparam int EXT_W   = NDIG * DIGIT_W;
   localparam int PROD_W  = COEF_WIDTH + DIGIT_W + 1;
   localparam int ACC_W   = DATA_WIDTH + COEF_WIDTH + FRAC_BITS;
   localparam int RND_W   = ACC_W - FRAC_BITS;
   localparam logic [DIG_IDX_W-1:0] TOP_DIGIT = DIG_IDX_W'(NDIG - 1);
   localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [EXT_W-1:0]  data_ext;
   logic [DIGIT_W-1:0]       digit_raw;
   logic signed [DIGIT_W:0]  digit_s;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  part_ext;
   logic [ACC_W-1:0]         part_shifted;
   logic [ACC_W-1:0]         rnd_sum;
   logic [RND_W-1:0]         rnd;
   logic [RND_W-DATA_WIDTH:0] upper;

   logic signed [PROD_W-1:0] partial_ff, partial_in;
   logic [DIG_IDX_W-1:0]     pshift_ff, pshift_in;
   logic                     pvalid_ff, pvalid_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;

   // Low digits are unsigned, the top digit carries the sign.
   assign data_ext  = EXT_W'($signed(data_op));
   assign digit_raw = data_ext[ctl.digit*DIGIT_W +: DIGIT_W];
   assign digit_s   = $signed({(ctl.digit == TOP_DIGIT) & digit_raw[DIGIT_W-1], digit_raw});
   assign prod      = $signed(coef_op) * digit_s;

   assign part_ext     = ACC_W'(partial_ff);
   assign part_shifted = part_ext << (pshift_ff * DIGIT_W);

   always_comb begin
      partial_in = prod;
      pshift_in  = ctl.digit;
      pvalid_in  = ctl.issue;
      acc_in     = acc_ff;
      if (ctl.acc_load) begin
         acc_in = ACC_W'($signed(init_op)) << FRAC_BITS;
      end else if (pvalid_ff) begin
         acc_in = acc_ff + part_shifted;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
      pshift_ff  <= pshift_in;
      acc_ff     <= acc_in;
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
      end
   end

   // Round to nearest with ties up, then saturate to the data width.
   assign rnd_sum = acc_ff + HALF_LSB;
   assign rnd     = rnd_sum[ACC_W-1:FRAC_BITS];
   assign upper   = rnd[RND_W-1:DATA_WIDTH-1];

   always_comb begin
      if (&upper || ~|upper) begin
         result = rnd[DATA_WIDTH-1:0];
      end else if (rnd[RND_W-1]) begin
         result = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   end

endmodule

@@ src/vpso_seq.sv @@
module vpso_seq #(
   parameter int NUM_DIGITS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   output vpso_pkg::seq_ctl_type ctl
);
   import vpso_pkg::*;

   localparam logic [DIG_IDX_W-1:0] LAST_DIGIT = DIG_IDX_W'(NUM_DIGITS - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ISSUE  = 6'b000010,
      S_DRAIN  = 6'b000100,
      S_ROUND  = 6'b001000,
      S_DIFF   = 6'b010000,
      S_FINISH = 6'b100000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic [TERM_W-1:0]    term_ff, term_in;
   logic [DIG_IDX_W-1:0] digit_ff, digit_in;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      digit_in = digit_ff;
      ctl      = '0;
      ctl.digit = digit_ff;
      ctl.term  = term_ff;
      ctl.idle  = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               term_in  = TERM_POLE;
               digit_in = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            ctl.issue    = 1'b1;
            ctl.acc_load = (digit_ff == '0) && term_first(term_ff);
            if (digit_ff == LAST_DIGIT) begin
               digit_in = '0;
               if (term_last(term_ff)) begin
                  state_in = S_DRAIN;
               end else begin
                  term_in = term_ff + TERM_W'(1);
               end
            end else begin
               digit_in = digit_ff + DIG_IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            ctl.round_wr = 1'b1;
            if (term_ff == TERM_FEED_OLD) begin
               state_in = S_DIFF;
            end else if (term_ff == TERM_STEP1) begin
               state_in = S_FINISH;
            end else begin
               term_in  = term_ff + TERM_W'(1);
               state_in = S_ISSUE;
            end
         end
         S_DIFF: begin
            ctl.diff_wr = 1'b1;
            term_in     = term_ff + TERM_W'(1);
            state_in    = S_ISSUE;
         end
         S_FINISH: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff  <= TERM_POLE;
         digit_ff <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         digit_ff <= digit_in;
      end
   end

endmodule

@@ src/velocity_prefilter_state_observer_core.sv @@
// Velocity prefilter and two-state observer.
// The req channel carries one request per sample: the raw velocity and the drive
// voltage. The block low-pass filters the velocity, then advances the observer by
// one Euler step, and returns both state estimates and the filtered velocity on
// the rsp channel. The user must write coefficients through the csr channel only
// while the block is idle; the block itself does not enforce this, and
// csr_ready is always high. One multiplier handles every product, one data
// digit of 24 bits per cycle; each data operand is split into D digits, where
// D = ceil((DATA_WIDTH+1)/24). The next request is taken in the cycle after
// the result is registered, and not while the previous one is in progress.
// The result sits in an output register. If the receiver stalls, the block
// finishes the next request and then waits with req_tready low until the
// register is free.
// Reset is synchronous: it clears the state estimates and filter history,
// restores the default coefficients and drops rsp_tvalid.
module velocity_prefilter_state_observer_core #(
   parameter int DATA_WIDTH = 40,
   parameter int COEF_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // velocity_sample, drive_voltage
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]           req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // estimate_first, estimate_second, filtered_velocity
   output logic [((3*DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [vpso_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [COEF_WIDTH-1:0]                       csr_data
);
   import vpso_pkg::*;

   localparam int RSP_W      = ((3*DATA_WIDTH+7)/8)*8;
   localparam int NUM_DIGITS = (DATA_WIDTH + DIGIT_W) / DIGIT_W;

   seq_ctl_type           ctl;
   logic                  req_accept;
   logic                  out_free;
   logic [COEF_WIDTH-1:0] coef_op;
   logic [DATA_WIDTH:0]   data_op;
   logic [DATA_WIDTH-1:0] init_op;
   logic [DATA_WIDTH-1:0] mac_result;

   logic [COEF_WIDTH-1:0] a21_ff, a21_in;
   logic [COEF_WIDTH-1:0] a22_ff, a22_in;
   logic [COEF_WIDTH-1:0] gain_ff, gain_in;
   logic [COEF_WIDTH-1:0] k0_ff, k0_in;
   logic [COEF_WIDTH-1:0] k1_ff, k1_in;
   logic [COEF_WIDTH-1:0] pole_ff, pole_in;
   logic [COEF_WIDTH-1:0] feed_ff, feed_in;
   logic [COEF_WIDTH-2:0] step_ff, step_in;

   logic [DATA_WIDTH-1:0] sample_ff, sample_in;
   logic [DATA_WIDTH-1:0] voltage_ff, voltage_in;
   logic [DATA_WIDTH-1:0] prev_raw_ff, prev_raw_in;
   logic [DATA_WIDTH-1:0] prev_filt_ff, prev_filt_in;
   logic [DATA_WIDTH-1:0] est_first_ff, est_first_in;
   logic [DATA_WIDTH-1:0] est_second_ff, est_second_in;
   logic [DATA_WIDTH-1:0] deriv_first_ff, deriv_first_in;
   logic [DATA_WIDTH-1:0] deriv_second_ff, deriv_second_in;
   logic [DATA_WIDTH:0]   diff_ff, diff_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_first_ff, rsp_first_in;
   logic [DATA_WIDTH-1:0] rsp_second_ff, rsp_second_in;
   logic [DATA_WIDTH-1:0] rsp_filt_ff, rsp_filt_in;

   assign req_tready = ctl.idle;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_filt_ff, rsp_second_ff, rsp_first_ff});

   vpso_seq #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .out_free (out_free),
      .ctl      (ctl)
   );

   vpso_mac #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .coef_op (coef_op),
      .data_op (data_op),
      .init_op (init_op),
      .result  (mac_result)
   );

   always_comb begin
      coef_op = pole_ff;
      data_op = (DATA_WIDTH+1)'($signed(prev_filt_ff));
      init_op = '0;
      unique case (ctl.term)
         TERM_POLE: begin
            coef_op = pole_ff;
            data_op = (DATA_WIDTH+1)'($signed(prev_filt_ff));
         end
         TERM_FEED_NEW: begin
            coef_op = feed_ff;
            data_op = (DATA_WIDTH+1)'($signed(sample_ff));
         end
         TERM_FEED_OLD: begin
            coef_op = feed_ff;
            data_op = (DATA_WIDTH+1)'($signed(prev_raw_ff));
         end
         TERM_K0: begin
            coef_op = k0_ff;
            data_op = diff_ff;
            init_op = est_second_ff;
         end
         TERM_A21: begin
            coef_op = a21_ff;
            data_op = (DATA_WIDTH+1)'($signed(est_first_ff));
         end
         TERM_A22: begin
            coef_op = a22_ff;
            data_op = (DATA_WIDTH+1)'($signed(est_second_ff));
         end
         TERM_GAIN: begin
            coef_op = gain_ff;
            data_op = (DATA_WIDTH+1)'($signed(voltage_ff));
         end
         TERM_K1: begin
            coef_op = k1_ff;
            data_op = diff_ff;
         end
         TERM_STEP0: begin
            coef_op = {1'b0, step_ff};
            data_op = (DATA_WIDTH+1)'($signed(deriv_first_ff));
            init_op = est_first_ff;
         end
         TERM_STEP1: begin
            coef_op = {1'b0, step_ff};
            data_op = (DATA_WIDTH+1)'($signed(deriv_second_ff));
            init_op = est_second_ff;
         end
         default: begin
            coef_op = pole_ff;
         end
      endcase
   end

   always_comb begin
      a21_in  = a21_ff;
      a22_in  = a22_ff;
      gain_in = gain_ff;
      k0_in   = k0_ff;
      k1_in   = k1_ff;
      pole_in = pole_ff;
      feed_in = feed_ff;
      step_in = step_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODEL_A21:            a21_in  = csr_data;
            REG_MODEL_A22:            a22_in  = csr_data;
            REG_INPUT_GAIN:           gain_in = csr_data;
            REG_OBSERVER_GAIN_FIRST:  k0_in   = csr_data;
            REG_OBSERVER_GAIN_SECOND: k1_in   = csr_data;
            REG_FILTER_POLE:          pole_in = csr_data;
            REG_FILTER_FEED:          feed_in = csr_data;
            REG_TIME_STEP:            step_in = csr_data[COEF_WIDTH-2:0];
            default: begin
               a21_in = a21_ff;
            end
         endcase
      end
   end

   always_comb begin
      sample_in       = sample_ff;
      voltage_in      = voltage_ff;
      prev_raw_in     = prev_raw_ff;
      prev_filt_in    = prev_filt_ff;
      est_first_in    = est_first_ff;
      est_second_in   = est_second_ff;
      deriv_first_in  = deriv_first_ff;
      deriv_second_in = deriv_second_ff;
      diff_in         = diff_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_filt_in     = rsp_filt_ff;
      if (req_accept) begin
         sample_in  = req_tdata[DATA_WIDTH-1:0];
         voltage_in = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      end
      if (ctl.round_wr) begin
         unique case (ctl.term)
            TERM_FEED_OLD: prev_filt_in    = mac_result;
            TERM_K0:       deriv_first_in  = mac_result;
            TERM_K1:       deriv_second_in = mac_result;
            TERM_STEP0:    est_first_in    = mac_result;
            TERM_STEP1:    est_second_in   = mac_result;
            default: begin
               prev_filt_in = prev_filt_ff;
            end
         endcase
      end
      if (ctl.diff_wr) begin
         diff_in = (DATA_WIDTH+1)'($signed(prev_filt_ff))
                 - (DATA_WIDTH+1)'($signed(est_first_ff));
      end
      if (ctl.finish) begin
         prev_raw_in   = sample_ff;
         rsp_valid_in  = 1'b1;
         rsp_first_in  = est_first_ff;
         rsp_second_in = est_second_ff;
         rsp_filt_in   = prev_filt_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      voltage_ff      <= voltage_in;
      deriv_first_ff  <= deriv_first_in;
      deriv_second_ff <= deriv_second_in;
      diff_ff         <= diff_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_second_ff   <= rsp_second_in;
      rsp_filt_ff     <= rsp_filt_in;
      if (reset) begin
         a21_ff        <= COEF_WIDTH'(RST_MODEL_A21);
         a22_ff        <= COEF_WIDTH'(RST_MODEL_A22);
         gain_ff       <= COEF_WIDTH'(RST_INPUT_GAIN);
         k0_ff         <= COEF_WIDTH'(RST_OBSERVER_GAIN_FIRST);
         k1_ff         <= COEF_WIDTH'(RST_OBSERVER_GAIN_SECOND);
         pole_ff       <= COEF_WIDTH'(RST_FILTER_POLE);
         feed_ff       <= COEF_WIDTH'(RST_FILTER_FEED);
         step_ff       <= (COEF_WIDTH-1)'(RST_TIME_STEP);
         prev_raw_ff   <= '0;
         prev_filt_ff  <= '0;
         est_first_ff  <= '0;
         est_second_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         a21_ff        <= a21_in;
         a22_ff        <= a22_in;
         gain_ff       <= gain_in;
         k0_ff         <= k0_in;
         k1_ff         <= k1_in;
         pole_ff       <= pole_in;
         feed_ff       <= feed_in;
         step_ff       <= step_in;
         prev_raw_ff   <= prev_raw_in;
         prev_filt_ff  <= prev_filt_in;
         est_first_ff  <= est_first_in;
         est_second_ff <= est_second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.finish))
      else $error("Result appeared without a finished request.");

   assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result register overwritten while still held.");

   assert property (@(posedge clock) disable iff (reset)
      !ctl.round_wr |=> $stable(est_first_ff) && $stable(est_second_ff))
      else $error("State estimate changed outside a write-back step.");
`endif

endmodule
